// ===== design/max_subtended_angle_search_unit_defines.svh =====
`ifndef MAX_SUBTENDED_ANGLE_SEARCH_UNIT_DEFINES_SVH
`define MAX_SUBTENDED_ANGLE_SEARCH_UNIT_DEFINES_SVH

// Implication checked on the same edge.
`define MSSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked on the next edge.
`define MSSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mssu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mssu_pkg;

  localparam int CoordW = 24;
  localparam int VecW   = 25;
  localparam int AccW   = 52;
  localparam int MagW   = 51;
  localparam int CorW   = 36;
  localparam int ZW     = 33;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  localparam logic [4:0] MUL_LAST    = 5'd9;
  localparam logic [4:0] SQR_LAST    = 5'd3;
  localparam logic [4:0] SQRT_FIRST  = 5'd31;
  localparam logic [4:0] CORDIC_LAST = 5'd30;

  // register indexes
  localparam logic [2:0] REG_END0_X = 3'd0;
  localparam logic [2:0] REG_END0_Y = 3'd1;
  localparam logic [2:0] REG_END0_Z = 3'd2;
  localparam logic [2:0] REG_END1_X = 3'd3;
  localparam logic [2:0] REG_END1_Y = 3'd4;
  localparam logic [2:0] REG_END1_Z = 3'd5;

  // accumulator slots
  localparam logic [1:0] ACC_CX  = 2'd0;
  localparam logic [1:0] ACC_CY  = 2'd1;
  localparam logic [1:0] ACC_CZ  = 2'd2;
  localparam logic [1:0] ACC_DOT = 2'd3;

  typedef logic signed [VecW-1:0] vcomp_t;

  typedef struct packed {
    vcomp_t [2:0] v0;
    vcomp_t [2:0] v1;
    logic         eval;
    logic         last;
  } mssu_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mssu_qstat_t;

  typedef struct packed {
    logic [1:0] a_idx;
    logic [1:0] b_idx;
    logic [1:0] acc;
    logic       neg;
  } mul_code_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_ABS, B_NORM, B_SQR, B_SQRT, B_CORDIC, B_FIN, B_DONE
  } mssu_state_t;

  // product schedule: cross terms then dot terms
  function automatic mul_code_t mul_code(input logic [4:0] j);
    mul_code_t c;
    c = '0;
    unique case (j)
      5'd0:    c = '{a_idx: 2'd1, b_idx: 2'd2, acc: ACC_CX,  neg: 1'b0};
      5'd1:    c = '{a_idx: 2'd2, b_idx: 2'd1, acc: ACC_CX,  neg: 1'b1};
      5'd2:    c = '{a_idx: 2'd2, b_idx: 2'd0, acc: ACC_CY,  neg: 1'b0};
      5'd3:    c = '{a_idx: 2'd0, b_idx: 2'd2, acc: ACC_CY,  neg: 1'b1};
      5'd4:    c = '{a_idx: 2'd0, b_idx: 2'd1, acc: ACC_CZ,  neg: 1'b0};
      5'd5:    c = '{a_idx: 2'd1, b_idx: 2'd0, acc: ACC_CZ,  neg: 1'b1};
      5'd6:    c = '{a_idx: 2'd0, b_idx: 2'd0, acc: ACC_DOT, neg: 1'b0};
      5'd7:    c = '{a_idx: 2'd1, b_idx: 2'd1, acc: ACC_DOT, neg: 1'b0};
      5'd8:    c = '{a_idx: 2'd2, b_idx: 2'd2, acc: ACC_DOT, neg: 1'b0};
      default: c = '0;
    endcase
    return c;
  endfunction

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] t;
    t = '0;
    unique case (i)
      5'd0:  t = 30'd843314857;
      5'd1:  t = 30'd497837829;
      5'd2:  t = 30'd263043837;
      5'd3:  t = 30'd133525159;
      5'd4:  t = 30'd67021687;
      5'd5:  t = 30'd33543516;
      5'd6:  t = 30'd16775851;
      5'd7:  t = 30'd8388437;
      5'd8:  t = 30'd4194283;
      5'd9:  t = 30'd2097149;
      5'd10: t = 30'd1048576;
      5'd11: t = 30'd524288;
      5'd12: t = 30'd262144;
      5'd13: t = 30'd131072;
      5'd14: t = 30'd65536;
      5'd15: t = 30'd32768;
      5'd16: t = 30'd16384;
      5'd17: t = 30'd8192;
      5'd18: t = 30'd4096;
      5'd19: t = 30'd2048;
      5'd20: t = 30'd1024;
      5'd21: t = 30'd512;
      5'd22: t = 30'd256;
      5'd23: t = 30'd128;
      5'd24: t = 30'd64;
      5'd25: t = 30'd32;
      5'd26: t = 30'd16;
      5'd27: t = 30'd8;
      5'd28: t = 30'd4;
      5'd29: t = 30'd2;
      5'd30: t = 30'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== design/mssu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mssu_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [23:0]           cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [71:0]           s_tdata,
  input  wire logic                  s_tuser,
  input  wire logic                  s_tlast,
  input  wire mssu_pkg::mssu_qstat_t qstat,
  output logic                       push,
  output mssu_pkg::mssu_item_t       item
);
  import mssu_pkg::*;

  logic signed [CoordW-1:0] end0 [3];
  logic signed [CoordW-1:0] end1 [3];
  logic signed [CoordW-1:0] pt   [3];
  logic z0, z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        end0[i] <= '0;
        end1[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_END0_X: end0[0] <= cfg_data;
        REG_END0_Y: end0[1] <= cfg_data;
        REG_END0_Z: end0[2] <= cfg_data;
        REG_END1_X: end1[0] <= cfg_data;
        REG_END1_Y: end1[1] <= cfg_data;
        REG_END1_Z: end1[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pt[0] = s_tdata[23:0];
  assign pt[1] = s_tdata[47:24];
  assign pt[2] = s_tdata[71:48];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item.v0[i] = VecW'(end0[i]) - VecW'(pt[i]);
      item.v1[i] = VecW'(end1[i]) - VecW'(pt[i]);
    end
    z0 = (item.v0 == '0);
    z1 = (item.v1 == '0);
    // points on an endpoint are not evaluated
    item.eval = s_tuser && !z0 && !z1;
    item.last = s_tlast;
  end

  assign s_tready = !qstat.full;
  assign push     = s_tvalid && s_tready;

endmodule
`default_nettype wire

// ===== design/mssu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mssu_queue #(
  parameter int W = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [W-1:0]          wdata,
  input  wire logic                  pop,
  output logic [W-1:0]               rdata,
  output mssu_pkg::mssu_qstat_t      qstat
);
  import mssu_pkg::*;

  logic [W-1:0] mem [4];
  logic [1:0]   wr_ptr, rd_ptr;
  logic [2:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  assign rdata       = mem[rd_ptr];
  assign qstat.full  = (count == 3'd4);
  assign qstat.empty = (count == 3'd0);

endmodule
`default_nettype wire

// ===== design/mssu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mssu_back #(
  parameter int MAX_POINTS      = 4096,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mssu_pkg::mssu_item_t  head,
  input  wire mssu_pkg::mssu_qstat_t qstat,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [31:0]                m_tdata
);
  import mssu_pkg::*;

  localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int AW  = ANGLE_FRAC_BITS + 2;
  localparam int SH  = 30 - ANGLE_FRAC_BITS;
  localparam logic [32:0] RND = 33'(1) << (29 - ANGLE_FRAC_BITS);

  mssu_state_t state, state_next;

  logic [4:0]              cnt;
  logic signed [VecW-1:0]  v0 [3];
  logic signed [VecW-1:0]  v1 [3];
  logic                    item_last;
  logic signed [AccW-1:0]  acc [4];
  logic [MagW-1:0]         m [4];
  logic                    dneg;
  mul_code_t               pcode, code;
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      prod;
  logic [63:0]             nrem, res, sq_bit, sq_try, res_next, nrem_next;
  logic                    sq_ge;
  logic signed [CorW-1:0]  cx, cy, dx, dy;
  logic signed [ZW-1:0]    cz;
  logic                    over;
  logic [31:0]             zc, ang;
  logic [32:0]             rnd;
  logic [AW-1:0]           angle;
  logic [AW-1:0]           best_angle;
  logic [PW-1:0]           best_position, position_counter;
  logic                    out_free;
  logic [11:0]             out_index;
  logic [17:0]             out_angle;

  assign code     = mul_code(cnt);
  assign over     = |{m[0][MagW-1:31], m[1][MagW-1:31], m[2][MagW-1:31], m[3][MagW-1:31]};
  assign out_free = !m_tvalid || m_tready;

  // one step of the restoring square root
  always_comb begin
    sq_bit = 64'(1) << {cnt, 1'b0};
    sq_try = res + sq_bit;
    sq_ge  = (nrem >= sq_try);
    if (sq_ge) begin
      nrem_next = nrem - sq_try;
      res_next  = (res >> 1) + sq_bit;
    end else begin
      nrem_next = nrem;
      res_next  = res >> 1;
    end
  end

  always_comb begin
    dx = cy >>> cnt;
    dy = cx >>> cnt;
  end

  always_comb begin
    if (cz < 0) begin
      zc = '0;
    end else if (cz > ZW'(HALF_PI_Q30)) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = cz[31:0];
    end
    ang   = dneg ? (PI_Q30 - zc) : zc;
    rnd   = (33'(ang) + RND) >> SH;
    angle = AW'(rnd);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!qstat.empty) state_next = head.eval ? B_MUL : B_DONE;
      B_MUL:    if (cnt == MUL_LAST) state_next = B_ABS;
      B_ABS:    state_next = B_NORM;
      B_NORM:   if (!over) state_next = B_SQR;
      B_SQR:    if (cnt == SQR_LAST) state_next = B_SQRT;
      B_SQRT:   if (cnt == '0) state_next = (res_next != '0) ? B_CORDIC : B_FIN;
      B_CORDIC: if (cnt == CORDIC_LAST) state_next = B_FIN;
      B_FIN:    state_next = B_DONE;
      B_DONE:   if (!item_last || out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // outputs of the sequencer: queue pop and the shared multiplier operands
  always_comb begin
    pop   = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      B_IDLE: pop = !qstat.empty;
      B_MUL: begin
        mul_a = 32'(v0[code.a_idx]);
        mul_b = 32'(v1[code.b_idx]);
      end
      B_SQR: begin
        mul_a = {1'b0, m[cnt[1:0]][30:0]};
        mul_b = {1'b0, m[cnt[1:0]][30:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          v0[i] <= head.v0[i];
          v1[i] <= head.v1[i];
        end
        item_last <= head.last;
        cnt       <= '0;
        for (int i = 0; i < 4; i++) acc[i] <= '0;
      end
      B_MUL: begin
        prod  <= mul_a * mul_b;
        pcode <= code;
        if (cnt != '0) begin
          acc[pcode.acc] <= pcode.neg ? acc[pcode.acc] - AccW'(prod)
                                      : acc[pcode.acc] + AccW'(prod);
        end
        cnt <= cnt + 5'd1;
      end
      B_ABS: begin
        for (int i = 0; i < 4; i++)
          m[i] <= (acc[i] < 0) ? MagW'(-acc[i]) : MagW'(acc[i]);
        dneg <= acc[ACC_DOT] < 0;
      end
      B_NORM: begin
        if (over) begin
          for (int i = 0; i < 4; i++) m[i] <= m[i] >> 1;
        end else begin
          cnt  <= '0;
          nrem <= '0;
        end
      end
      B_SQR: begin
        prod <= mul_a * mul_b;
        if (cnt != '0) nrem <= nrem + 64'(prod);
        cnt <= cnt + 5'd1;
        if (cnt == SQR_LAST) begin
          cnt <= SQRT_FIRST;
          res <= '0;
        end
      end
      B_SQRT: begin
        nrem <= nrem_next;
        res  <= res_next;
        cnt  <= cnt - 5'd1;
        if (cnt == '0) begin
          cx  <= CorW'(m[3]);
          cy  <= CorW'(res_next);
          cz  <= '0;
          cnt <= '0;
        end
      end
      B_CORDIC: begin
        if (cy > 0) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + ZW'(atan_q30(cnt));
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - ZW'(atan_q30(cnt));
        end
        cnt <= cnt + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_angle       <= '0;
      best_position    <= '0;
      position_counter <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == B_FIN && best_angle < angle) begin
        best_angle    <= angle;
        best_position <= position_counter;
      end
      if (state == B_DONE) begin
        if (item_last) begin
          if (out_free) begin
            m_tvalid         <= 1'b1;
            out_index        <= 12'(best_position);
            out_angle        <= 18'(best_angle);
            best_angle       <= '0;
            best_position    <= '0;
            position_counter <= '0;
          end
        end else if (position_counter == PW'(MAX_POINTS - 1)) begin
          position_counter <= '0;
        end else begin
          position_counter <= position_counter + PW'(1);
        end
      end
    end
  end

  assign m_tdata = {2'b00, out_angle, out_index};

endmodule
`default_nettype wire

// ===== design/max_subtended_angle_search_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Finds, over a run of 3D points, the point that sees the two configured
// endpoints under the largest angle, and gives its run position and the angle
// (radians, unsigned Q2.16) on the item marked tlast. Points are taken into a
// four-entry queue, so input keeps flowing while a result waits on m_tready.
// The back end works one point at a time: a real point goes through 9
// products and 3 squares on one 32x32 multiplier, up to 19 normalizing
// shifts, a 32-step square root and a 31-step CORDIC that is skipped when
// the cross product is zero, each one step per cycle; a padding point or
// one on an endpoint goes from idle straight to done. A last item also holds
// the back end until the output register is free to take its result.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module max_subtended_angle_search_unit #(
  parameter int MAX_POINTS      = 4096,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // point_x, point_y, point_z
  input  wire logic        s_tuser,   // is_real
  input  wire logic        s_tlast,   // is_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // max_index, max_angle, zero pad
);
  import mssu_pkg::*;

  mssu_item_t  item, head;
  mssu_qstat_t qstat;
  logic        push, pop;

  mssu_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .qstat, .push, .item
  );

  mssu_queue #(.W($bits(mssu_item_t))) u_queue (
    .clk, .rst, .push, .wdata(item), .pop, .rdata(head), .qstat
  );

  mssu_back #(
    .MAX_POINTS(MAX_POINTS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk, .rst, .head, .qstat, .pop, .m_tvalid, .m_tready, .m_tdata
  );

endmodule
`default_nettype wire

// ===== design/mssu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "max_subtended_angle_search_unit_defines.svh"
module mssu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);
  `MSSU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `MSSU_ASSERT_NOW(a_angle_range, m_tvalid, m_tdata[29:12] <= 18'd205887, "angle above pi")
  `MSSU_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[31:30] == 2'b00, "pad bits set")
  `MSSU_ASSERT_NEXT(a_no_early, $past(rst) && !m_tvalid && !(s_tvalid && s_tready && s_tlast),
                    !m_tvalid, "result without a last item")
endmodule

bind max_subtended_angle_search_unit mssu_checker u_mssu_checker (.*);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import mssu_pkg::*;

  localparam int QuietLimit = 20000;
  localparam int DrainCycles = 300;

  // atan(2^-i) in Q30, one entry per rotation step
  localparam longint AtanTab[31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1};

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // angle between a and b, Q2.16 radians; neither vector may be zero
  function automatic logic [17:0] subtended(longint a0, a1, a2, b0, b1, b2);
    longint cx, cy, cz, dotp, x, y, z, dx, dy, ang;
    longint unsigned m[4];
    longint unsigned top;
    int sh;
    cx = a1 * b2 - a2 * b1;
    cy = a2 * b0 - a0 * b2;
    cz = a0 * b1 - a1 * b0;
    dotp = a0 * b0 + a1 * b1 + a2 * b2;
    m[0] = magnitude(cx); m[1] = magnitude(cy);
    m[2] = magnitude(cz); m[3] = magnitude(dotp);
    top = m[0];
    for (int i = 1; i < 4; i++) if (m[i] > top) top = m[i];
    sh = 0;
    while ((top >> sh) >= (64'd1 << 31)) sh++;
    for (int i = 0; i < 4; i++) m[i] >>= sh;
    y = longint'(int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]));
    x = longint'(m[3]);
    z = 0;
    if (y != 0) begin
      for (int i = 0; i < 31; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += AtanTab[i];
        end else begin
          x -= dx; y += dy; z -= AtanTab[i];
        end
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    ang = dotp < 0 ? longint'(PI_Q30) - z : z;
    ang = (ang + (64'sd1 << 13)) >>> 14;
    return ang[17:0];
  endfunction

  class angle_scoreboard;
    logic signed [23:0] endpoint[6];
    logic [17:0] best_ang;
    logic [11:0] best_pos, run_pos;
    logic [29:0] expected_q[$];
    int errors, shown;

    function new();
      foreach (endpoint[i]) endpoint[i] = '0;
      best_ang = '0; best_pos = '0; run_pos = '0;
      errors = 0; shown = 0;
    endfunction

    function void set_endpoint(int idx, logic [23:0] val);
      if (idx < 6) endpoint[idx] = val;
    endfunction

    function void note_point(logic signed [23:0] px, py, pz, logic real_pt, logic last_pt);
      longint v0[3], v1[3];
      logic [17:0] ang;
      if (real_pt) begin
        v0[0] = longint'(endpoint[0]) - px; v0[1] = longint'(endpoint[1]) - py;
        v0[2] = longint'(endpoint[2]) - pz;
        v1[0] = longint'(endpoint[3]) - px; v1[1] = longint'(endpoint[4]) - py;
        v1[2] = longint'(endpoint[5]) - pz;
        // a point sitting on an endpoint has no angle
        if ((v0[0] | v0[1] | v0[2]) != 0 && (v1[0] | v1[1] | v1[2]) != 0) begin
          ang = subtended(v0[0], v0[1], v0[2], v1[0], v1[1], v1[2]);
          if (best_ang < ang) begin
            best_ang = ang;
            best_pos = run_pos;
          end
        end
      end
      if (last_pt) begin
        expected_q.push_back({best_ang, best_pos});
        best_ang = '0; best_pos = '0; run_pos = '0;
      end else begin
        run_pos = run_pos + 12'd1;
      end
    endfunction

    function void check_result(logic [31:0] d);
      logic [29:0] exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: index %0d angle %0d", d[11:0], d[29:12]);
        end
        return;
      end
      exp_r = expected_q.pop_front();
      if (d[11:0] !== exp_r[11:0] || d[29:12] !== exp_r[29:12]) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: index exp %0d got %0d, angle exp %0d got %0d",
                   exp_r[11:0], d[11:0], exp_r[29:12], d[29:12]);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;   // point_x, point_y, point_z
  logic s_tuser = 1'b0;        // is_real
  logic s_tlast = 1'b0;        // is_last
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;        // max_index, max_angle, zero pad

  int send_idle = 0;
  int recv_idle = 0;
  int quiet = 0;
  angle_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  max_subtended_angle_search_unit dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      quiet <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_endpoint(idx, val);
  endtask

  task automatic write_ends(logic [23:0] e[6]);
    write_reg(REG_END0_X, e[0]); write_reg(REG_END0_Y, e[1]);
    write_reg(REG_END0_Z, e[2]); write_reg(REG_END1_X, e[3]);
    write_reg(REG_END1_Y, e[4]); write_reg(REG_END1_Z, e[5]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(logic [23:0] px, py, pz, logic real_pt, logic last_pt);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pz, py, px};
    s_tuser <= real_pt;
    s_tlast <= last_pt;
    do @(posedge clk); while (!s_tready);
    sb.note_point(px, py, pz, real_pt, last_pt);
  endtask

  // block is idle once every result is back and the back end has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1, 2: return 24'($signed($urandom_range(0, 8000)) - 4000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_run(int len);
    logic [23:0] px, py, pz;
    int k;
    for (int i = 0; i < len; i++) begin
      px = rand_coord(); py = rand_coord(); pz = rand_coord();
      if ($urandom_range(0, 15) == 0) begin
        k = $urandom_range(0, 1) * 3;
        px = sb.endpoint[k]; py = sb.endpoint[k + 1]; pz = sb.endpoint[k + 2];
      end else if ($urandom_range(0, 9) == 0) begin
        px = sb.endpoint[0] + 24'($signed($urandom_range(0, 6)) - 3);
        py = sb.endpoint[1]; pz = sb.endpoint[2];
      end
      send_point(px, py, pz, $urandom_range(0, 4) != 0, i == len - 1);
    end
  endtask

  initial begin
    logic [23:0] e[6];
    int len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all endpoints at the origin: every angle is zero
    e = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
    write_ends(e);
    send_point(24'd100, 24'd5, 24'd7, 1'b1, 1'b0);
    send_point(24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
    settle();

    e = '{24'd1024, 24'd0, 24'd0, 24'd0, 24'd1024, 24'd0};
    write_ends(e);
    write_reg(3'd6, 24'hFFFFFF);   // out of range, ignored
    write_reg(3'd7, 24'h123456);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_point(24'd1024, 24'd0, 24'd0, 1'b1, 1'b0);          // on an endpoint
    send_point(24'd0, 24'd0, 24'd0, 1'b0, 1'b0);             // padding
    send_point(24'd0, 24'd0, 24'd0, 1'b1, 1'b0);             // right angle
    send_point(24'd0, 24'd0, 24'd0, 1'b1, 1'b0);             // tie
    send_point(24'd512, 24'd512, 24'd0, 1'b1, 1'b0);         // straight angle
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0);
    send_point(24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0);
    send_point(24'h800000, 24'h7FFFFF, 24'h000001, 1'b1, 1'b1);
    send_point(24'd0, 24'd0, 24'd0, 1'b0, 1'b1);             // padding only
    send_point(24'd300, 24'd300, 24'd9, 1'b1, 1'b0);
    send_point(24'd0, 24'd0, 24'd0, 1'b0, 1'b1);             // padding last
    send_point(24'd0, 24'd1024, 24'd0, 1'b1, 1'b1);          // lone skip
    send_point(24'h000001, 24'hFFFFFF, 24'h555555, 1'b1, 1'b0);
    send_point(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1, 1'b1);
    settle();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase / 3)
        0: begin send_idle = 29; recv_idle = 87; end
        1: begin send_idle = 87; recv_idle = 29; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (phase == 0)
        e = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000};
      else if (phase == 1)
        e = '{24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF};
      else
        foreach (e[i]) e[i] = rand_coord();
      write_ends(e);
      for (int n = 0; n < 90; n += len) begin
        len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 16);
        random_run(len);
      end
      settle();
    end

    if (sb.expected_q.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
